>>> sv/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set: request codes, response
// codes, control states and the update command sent to the cell chain.
// ----------------------------------------------------------------------------
package sus_pkg;

    localparam int VALUE_W  = 32;
    localparam int OUT_W    = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_NOTFOUND  = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_FOUND     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic ins;
        logic del;
    } upd_cmd_t;

endpackage

>>> sv/sorted_unique_set_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_core
// Bounded set of distinct signed values with insert, delete and lookup.
// ----------------------------------------------------------------------------
// The set is held in a chain of CAPACITY cells, kept physically ascending;
// the order bit only changes how ranks are reported, so it may be rewritten
// at any idle time. One request word is taken at a time: a start cycle, a
// scan token that walks the chain one cell per cycle, then an update cycle
// that shifts the cells in parallel and registers the response. The next
// word can be accepted once that update has been made. A new word is
// accepted while the previous response waits, but its update is held
// until that response has been taken.
module sorted_unique_set_core #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic signed [sus_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sus_pkg::STATUS_W-1:0]       status,
    output logic [sus_pkg::OUT_W-1:0]          position,
    output logic [sus_pkg::OUT_W-1:0]          entry_count
);
    import sus_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] req_value;
    logic                      start;
    logic [CNT_W-1:0]          count;
    upd_cmd_t                  upd;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CNT_W-1:0]          tok_cnt    [CAPACITY];
    logic [CAPACITY-1:0]       lt_flag;
    logic [CAPACITY-1:0]       tok_valid;
    logic [CAPACITY-1:0]       tok_hit;
    logic [CAPACITY-1:0]       occ;

    sus_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .entry_count (entry_count),
        .req_value   (req_value),
        .start       (start),
        .count       (count),
        .upd         (upd),
        .tok_valid   (tok_valid[CAPACITY-1]),
        .tok_cnt     (tok_cnt[CAPACITY-1]),
        .tok_hit     (tok_hit[CAPACITY-1])
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                      prev_lt;
        logic signed [VALUE_W-1:0] prev_value;
        logic signed [VALUE_W-1:0] next_value;
        logic                      tin_valid;
        logic [CNT_W-1:0]          tin_cnt;
        logic                      tin_hit;

        assign occ[i] = (CNT_W'(i) < count);

        if (i == 0)
        begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_value = req_value;
            assign tin_valid  = start;
            assign tin_cnt    = '0;
            assign tin_hit    = 1'b0;
        end
        else
        begin : g_body
            assign prev_lt    = lt_flag[i-1];
            assign prev_value = cell_value[i-1];
            assign tin_valid  = tok_valid[i-1];
            assign tin_cnt    = tok_cnt[i-1];
            assign tin_hit    = tok_hit[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
        end

        sus_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .req_value     (req_value),
            .upd           (upd),
            .occupied      (occ[i]),
            .prev_lt       (prev_lt),
            .prev_value    (prev_value),
            .next_value    (next_value),
            .tok_in_valid  (tin_valid),
            .tok_in_cnt    (tin_cnt),
            .tok_in_hit    (tin_hit),
            .value         (cell_value[i]),
            .lt_flag       (lt_flag[i]),
            .tok_out_valid (tok_valid[i]),
            .tok_out_cnt   (tok_cnt[i]),
            .tok_out_hit   (tok_hit[i])
        );
    end

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tok_valid, start}))
        else $error("More than one scan token in the chain.");

    a_busy_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid != '0) |-> !in_ready)
        else $error("A word was offered as accepted during a scan.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_FULL)) |-> (count == CNT_W'(CAPACITY)))
        else $error("Full response while the set has room.");
`endif

endmodule

>>> sv/sus_cell.sv
// ----------------------------------------------------------------------------
// sus_cell
// One entry of the set. Holds a value, compares it with the request as the
// scan token passes, and shifts toward or away from its neighbors on update.
// ----------------------------------------------------------------------------
module sus_cell #(
    parameter int CNT_W = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [sus_pkg::VALUE_W-1:0]     req_value,
    input  sus_pkg::upd_cmd_t                      upd,
    input  logic                                   occupied,
    input  logic                                   prev_lt,
    input  logic signed [sus_pkg::VALUE_W-1:0]     prev_value,
    input  logic signed [sus_pkg::VALUE_W-1:0]     next_value,
    input  logic                                   tok_in_valid,
    input  logic [CNT_W-1:0]                       tok_in_cnt,
    input  logic                                   tok_in_hit,
    output logic signed [sus_pkg::VALUE_W-1:0]     value,
    output logic                                   lt_flag,
    output logic                                   tok_out_valid,
    output logic [CNT_W-1:0]                       tok_out_cnt,
    output logic                                   tok_out_hit
);
    import sus_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      lt_flag_reg;
    logic                      lt_flag_next;
    logic                      tok_valid_reg;
    logic [CNT_W-1:0]          tok_cnt_reg;
    logic                      tok_hit_reg;
    logic                      is_lt;
    logic                      is_eq;

    assign is_lt = occupied && (value_reg < req_value);
    assign is_eq = occupied && (value_reg == req_value);

    always_comb
    begin
        value_next   = value_reg;
        lt_flag_next = tok_in_valid ? is_lt : lt_flag_reg;
        if (upd.ins && !lt_flag_reg)
        begin
            value_next = prev_lt ? req_value : prev_value;
        end
        else if (upd.del && !lt_flag_reg)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        lt_flag_reg <= lt_flag_next;
        tok_cnt_reg <= tok_in_cnt + CNT_W'(is_lt);
        tok_hit_reg <= tok_in_hit | is_eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    assign value         = value_reg;
    assign lt_flag       = lt_flag_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_cnt   = tok_cnt_reg;
    assign tok_out_hit   = tok_hit_reg;

endmodule

>>> sv/sus_ctrl.sv
// ----------------------------------------------------------------------------
// sus_ctrl
// Request sequencer. Takes one word, launches the scan token down the cell
// chain, decides the response from the token's totals and drives the update.
// ----------------------------------------------------------------------------
module sus_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             operation,
    input  logic signed [sus_pkg::VALUE_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sus_pkg::STATUS_W-1:0]           status,
    output logic [sus_pkg::OUT_W-1:0]              position,
    output logic [sus_pkg::OUT_W-1:0]              entry_count,
    output logic signed [sus_pkg::VALUE_W-1:0]     req_value,
    output logic                                   start,
    output logic [CNT_W-1:0]                       count,
    output sus_pkg::upd_cmd_t                      upd,
    input  logic                                   tok_valid,
    input  logic [CNT_W-1:0]                       tok_cnt,
    input  logic                                   tok_hit
);
    import sus_pkg::*;

    state_t                    state_reg;
    state_t                    state_next;
    logic [1:0]                op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      start_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      desc_reg;
    logic [CNT_W-1:0]          lt_reg;
    logic                      hit_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [OUT_W-1:0]          pos_reg;
    logic [OUT_W-1:0]          ecnt_reg;
    logic                      accept;
    logic                      fire;
    logic [CNT_W-1:0]          rank;
    logic [CNT_W+OUT_W-1:0]    rank_ext;
    logic [CNT_W+OUT_W-1:0]    count_ext;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign fire   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tok_valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // In descending order the rank counts the entries above the value.
    assign rank = desc_reg ? (count_reg - lt_reg - CNT_W'(hit_reg)) : lt_reg;
    assign rank_ext  = {{OUT_W{1'b0}}, rank};
    assign count_ext = {{OUT_W{1'b0}}, count_next};

    always_comb
    begin
        upd         = '0;
        count_next  = count_reg;
        status_next = STAT_NOTFOUND;
        case (op_reg)
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = STAT_DUPLICATE;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    status_next = STAT_INSERTED;
                    upd.ins     = fire;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (hit_reg)
                begin
                    status_next = STAT_DELETED;
                    upd.del     = fire;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = hit_reg ? STAT_FOUND : STAT_NOTFOUND;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                desc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
        if ((state_reg == ST_WALK) && tok_valid)
        begin
            lt_reg  <= tok_cnt;
            hit_reg <= tok_hit;
        end
        if (fire)
        begin
            status_reg <= status_next;
            pos_reg    <= rank_ext[OUT_W-1:0];
            ecnt_reg   <= count_ext[OUT_W-1:0];
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = pos_reg;
    assign entry_count = ecnt_reg;
    assign req_value   = value_reg;
    assign start       = start_reg;
    assign count       = count_reg;

endmodule
